// ===== hdl/ssd_pkg.sv =====
// Shared constants and types for the seven-segment scan driver.
`timescale 1ns / 1ps

package ssd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int POS_W      = (NUM_DIGITS > 2) ? $clog2(NUM_DIGITS) : 1;
    localparam int SEC_DIGITS = NUM_DIGITS / 2;
    localparam int POS_AT_FF  = 255 % NUM_DIGITS;

    localparam logic [7:0] PERIOD_RESET = 8'd160;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef logic [3:0]                   t_digit;
    typedef t_digit [NUM_DIGITS-1:0]      t_digit_vec;

    typedef struct packed {
        logic                 is_load;
        t_digit_vec           digits;
        logic [POS_W-1:0]     start_pos;
    } t_cmd;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_RECIP,
        FS_SPLIT,
        FS_TENS,
        FS_PUSH,
        FS_REM
    } t_front_state;

endpackage

// ===== hdl/ssd_front.sv =====
// Front end: accepts items, splits load values into digits, tracks the scan state.
`timescale 1ns / 1ps

module ssd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [15:0]           i_seconds,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    output logic                  o_push,
    output ssd_pkg::t_cmd         o_cmd,
    input  logic                  i_q_full
);
    import ssd_pkg::*;

    // floor(x / 60) == (x * 34953) >> 21 for every 16-bit x
    localparam logic [31:0] RECIP60 = 32'd34953;

    function automatic logic [4:0] div10(input logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd205;
        return p[15:11];
    endfunction

    function automatic logic [1:0] div100(input logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd41;
        return p[13:12];
    endfunction

    t_front_state     r_state, n_state;
    logic [7:0]       r_period, n_period;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_offset, n_offset;
    logic             r_dir, n_dir;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_total, n_total;
    logic [10:0]      r_quot, n_quot;
    logic [5:0]       r_secs, n_secs;
    logic [7:0]       r_mins, n_mins;
    logic [2:0]       r_s_q10, n_s_q10;
    logic [4:0]       r_m_q10, n_m_q10;
    logic [1:0]       r_m_q100, n_m_q100;
    logic [8:0]       r_num, n_num;
    logic [8:0]       r_p9, n_p9;
    logic [8:0]       r_rem, n_rem;
    logic [3:0]       r_bit, n_bit;

    logic             accept;
    logic             step;
    logic [8:0]       p9_now;
    logic [8:0]       num_now;
    logic [31:0]      prod;
    logic [16:0]      times60;
    logic [16:0]      diff;
    logic [9:0]       shifted;
    logic [9:0]       trial;
    logic [7:0]       off_step;
    t_digit           s_ones, s_tens, m_ones, m_tens, m_hund;
    t_digit_vec       digits;
    logic [5:0]       s_ones_w;
    logic [7:0]       m_ones_w;
    logic [4:0]       m_tens_w;

    assign o_in_ready = (r_state == FS_IDLE) && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign p9_now  = (r_period == 8'd0) ? 9'd256 : {1'b0, r_period};
    assign num_now = {1'b0, r_count} + 9'd1;

    assign prod    = 32'(r_total) * RECIP60;
    assign times60 = {r_quot, 6'b0} - {4'b0, r_quot, 2'b0};
    assign diff    = {1'b0, r_total} - times60;

    assign shifted = {r_rem, r_num[r_bit]};
    assign trial   = (shifted >= {1'b0, r_p9}) ? (shifted - {1'b0, r_p9}) : shifted;

    assign off_step = r_dir ? (r_offset - 8'd1) : (r_offset + 8'd1);

    // Decimal digits of seconds (two) and minutes (three)
    assign s_ones_w = r_secs - ({r_s_q10, 3'b0} + {2'b0, r_s_q10, 1'b0});
    assign m_ones_w = r_mins - ({r_m_q10, 3'b0} + {2'b0, r_m_q10, 1'b0});
    assign m_tens_w = r_m_q10 - ({r_m_q100, 3'b0} + {2'b0, r_m_q100, 1'b0});
    assign s_ones   = s_ones_w[3:0];
    assign s_tens   = {1'b0, r_s_q10};
    assign m_ones   = m_ones_w[3:0];
    assign m_tens   = m_tens_w[3:0];
    assign m_hund   = {2'b0, r_m_q100};

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (i < SEC_DIGITS) begin
                if (i == 0) digits[i] = s_ones;
                else if (i == 1) digits[i] = s_tens;
                else digits[i] = '0;
            end else begin
                if (i - SEC_DIGITS == 0) digits[i] = m_ones;
                else if (i - SEC_DIGITS == 1) digits[i] = m_tens;
                else if (i - SEC_DIGITS == 2) digits[i] = m_hund;
                else digits[i] = '0;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_period = i_cfg_wr_en ? i_cfg_wr_data : r_period;
        n_count  = r_count;
        n_offset = r_offset;
        n_dir    = r_dir;
        n_pos    = r_pos;
        n_total  = r_total;
        n_quot   = r_quot;
        n_secs   = r_secs;
        n_mins   = r_mins;
        n_s_q10  = r_s_q10;
        n_m_q10  = r_m_q10;
        n_m_q100 = r_m_q100;
        n_num    = r_num;
        n_p9     = r_p9;
        n_rem    = r_rem;
        n_bit    = r_bit;
        step     = 1'b0;
        o_push   = 1'b0;
        o_cmd.is_load   = 1'b0;
        o_cmd.digits    = digits;
        o_cmd.start_pos = r_pos;

        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_LOAD) begin
                        n_total = i_seconds;
                        n_state = FS_RECIP;
                    end else begin
                        o_push = 1'b1;
                        if (num_now < p9_now) begin
                            n_count = num_now[7:0];
                        end else if (num_now == p9_now) begin
                            n_count = 8'd0;
                            step    = 1'b1;
                        end else begin
                            // count left above a freshly written period
                            n_num   = num_now;
                            n_p9    = p9_now;
                            n_rem   = '0;
                            n_bit   = 4'd8;
                            n_state = FS_REM;
                        end
                    end
                end
            end
            FS_RECIP: begin
                n_quot  = prod[31:21];
                n_state = FS_SPLIT;
            end
            FS_SPLIT: begin
                n_secs  = diff[5:0];
                n_mins  = r_quot[7:0];
                n_state = FS_TENS;
            end
            FS_TENS: begin
                n_s_q10  = 3'(div10({2'b0, r_secs}));
                n_m_q10  = div10(r_mins);
                n_m_q100 = div100(r_mins);
                n_state  = FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_q_full) begin
                    o_push        = 1'b1;
                    o_cmd.is_load = 1'b1;
                    n_state       = FS_IDLE;
                end
            end
            FS_REM: begin
                n_rem = trial[8:0];
                n_bit = r_bit - 4'd1;
                if (r_bit == 4'd0) begin
                    n_count = trial[7:0];
                    step    = (trial == 10'd0);
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase

        if (step) begin
            n_offset = off_step;
            n_dir    = (off_step == 8'd1 || off_step == 8'(NUM_DIGITS - 2)) ? ~r_dir : r_dir;
            if (r_dir) begin
                if (r_offset == 8'd0) n_pos = POS_W'(POS_AT_FF);
                else if (r_pos == '0) n_pos = POS_W'(NUM_DIGITS - 1);
                else n_pos = r_pos - POS_W'(1);
            end else begin
                if (r_offset == 8'hFF) n_pos = '0;
                else if (r_pos == POS_W'(NUM_DIGITS - 1)) n_pos = '0;
                else n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_count  <= '0;
            r_offset <= '0;
            r_dir    <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_period <= n_period;
            r_count  <= n_count;
            r_offset <= n_offset;
            r_dir    <= n_dir;
            r_pos    <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_quot   <= n_quot;
        r_secs   <= n_secs;
        r_mins   <= n_mins;
        r_s_q10  <= n_s_q10;
        r_m_q10  <= n_m_q10;
        r_m_q100 <= n_m_q100;
        r_num    <= n_num;
        r_p9     <= n_p9;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
    end

endmodule

// ===== hdl/ssd_queue.sv =====
// Two-entry command queue between the front end and the frame generator.
`timescale 1ns / 1ps

module ssd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssd_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output ssd_pkg::t_cmd  o_cmd,
    output logic           o_empty
);
    import ssd_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) n_count = r_count + (Q_PTR_W + 1)'(1);
        else if (!do_push && do_pop) n_count = r_count - (Q_PTR_W + 1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/ssd_back.sv =====
// Back end: holds the digit store and emits one registered frame per digit position.
`timescale 1ns / 1ps

module ssd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ssd_pkg::t_cmd  i_cmd,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_segment_pattern,
    output logic [7:0]     o_digit_select,
    output logic           o_last_frame
);
    import ssd_pkg::*;

    function automatic logic [7:0] seg_lookup(input t_digit d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'b11000000;
            4'd1:    p = 8'b11001111;
            4'd2:    p = 8'b10100100;
            4'd3:    p = 8'b10000110;
            4'd4:    p = 8'b10001011;
            4'd5:    p = 8'b10010010;
            4'd6:    p = 8'b10010000;
            4'd7:    p = 8'b11000111;
            4'd8:    p = 8'b10000000;
            4'd9:    p = 8'b10000010;
            default: p = 8'b11000000;
        endcase
        return p;
    endfunction

    t_digit_vec       r_store;
    logic             r_active, n_active;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_seg, r_sel;
    logic             r_last;

    logic             emit;
    logic             last_now;
    logic [7:0]       pat;

    assign emit     = r_active && (!r_out_valid || i_out_ready);
    assign last_now = (r_cnt == POS_W'(NUM_DIGITS - 1));
    assign o_pop    = !i_q_empty && (!r_active || (emit && last_now));

    always_comb begin
        pat = seg_lookup(r_store[r_pos]);
        if (r_pos == POS_W'(1)) pat[7] = 1'b0;
    end

    always_comb begin
        n_active    = r_active;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (emit) begin
            n_out_valid = 1'b1;
            n_cnt       = r_cnt + POS_W'(1);
            n_pos       = (r_pos == POS_W'(NUM_DIGITS - 1)) ? '0 : r_pos + POS_W'(1);
            if (last_now) n_active = 1'b0;
        end
        if (o_pop && !i_cmd.is_load) begin
            n_active = 1'b1;
            n_pos    = i_cmd.start_pos;
            n_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_store     <= '0;
        end else begin
            r_active    <= n_active;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (o_pop && i_cmd.is_load) begin
                r_store <= i_cmd.digits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_seg  <= pat;
            r_sel  <= 8'd1 << r_pos;
            r_last <= last_now;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_segment_pattern = r_seg;
    assign o_digit_select    = r_sel;
    assign o_last_frame      = r_last;

endmodule

// ===== hdl/seven_segment_scan_driver_core.sv =====
// Top level of the seven-segment scan driver: front end, command queue, frame generator.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready): each item carries i_opcode and
//   i_seconds. A load item (OP_LOAD) converts i_seconds to minutes:seconds
//   and stores the decimal digits; it produces no frames. A refresh item
//   (OP_REFRESH) produces NUM_DIGITS frames on the output channel.
//   Output channel (o_out_valid / i_out_ready): one frame per digit position
//   with an active-low segment pattern, a one-hot digit select, and
//   o_last_frame on the final frame of the refresh.
//   Configuration: i_cfg_wr_en loads i_cfg_wr_data as the rotate period.
// Timing
//   A refresh is queued, then taken up by the frame generator, whose single
//   frame output register holds each frame; frames follow one per cycle
//   while the receiver is ready, and the next refresh is popped as the last
//   frame is emitted, so back-to-back refreshes leave no gap. A load passes
//   through reciprocal multiply, split, tens and push. A refresh that finds
//   its counter above a newly written period runs the bit-serial remainder.
// Reset and stall
//   Reset clears the digit store, refresh counter, offset and direction,
//   and sets the period to 160. A stalled receiver holds the current frame;
//   the two-entry queue keeps the front end accepting until it fills.
module seven_segment_scan_driver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_seconds,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_segment_pattern,
    output logic [7:0]  o_digit_select,
    output logic        o_last_frame
);
    import ssd_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_cmd push_cmd, head_cmd;

    // Accept items, split load values into digits, advance the scan offset
    ssd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_seconds     (i_seconds),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (q_push),
        .o_cmd         (push_cmd),
        .i_q_full      (q_full)
    );

    // Hold commands so the front end and frame generator stall independently
    ssd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    // Apply loads in order and drive frames
    ssd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (head_cmd),
        .i_q_empty         (q_empty),
        .o_pop             (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_segment_pattern (o_segment_pattern),
        .o_digit_select    (o_digit_select),
        .o_last_frame      (o_last_frame)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_digit_select))
        else $error("digit select is not one-hot");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the seven-segment scan driver core.
`timescale 1ns / 1ps

module tb_top;
    import ssd_pkg::*;

    // Longest legal quiet stretch: a receiver hold-off, a sender gap, a drain
    // pause and the block's own load and remainder steps. Take that several
    // times over.
    localparam int unsigned STALL_LIMIT  = 1000;
    // Let a load or a remainder pass finish
    // before touching the period register.
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned REPORT_MAX   = 10;

    // Active-low segment font for digits 0 to 9, decimal point off.
    localparam logic [7:0] SEG_FONT [0:9] = '{
        8'hC0, 8'hCF, 8'hA4, 8'h86, 8'h8B, 8'h92, 8'h90, 8'hC7, 8'h80, 8'h82
    };

    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] select;
        logic       last;
    } t_frame;

    // Digit store, scan state and period of the display, plus the frames
    // that accepted refresh items still owe.
    class frame_predictor;
        t_digit      shown [NUM_DIGITS];
        int unsigned refresh_cnt;
        int unsigned start_offset;
        int unsigned period;
        bit          step_down;
        t_frame      frames_due [$];
        int unsigned failures;

        function new();
            foreach (shown[i]) shown[i] = '0;
            refresh_cnt  = 0;
            start_offset = 0;
            step_down    = 1'b0;
            period       = PERIOD_RESET;
            failures     = 0;
        endfunction

        // Update the display state for one accepted item and queue its frames.
        function void note_item(input logic op, input logic [15:0] secs);
            int unsigned sec_part;
            int unsigned min_part;
            int unsigned pos;
            int unsigned digit;
            t_frame      f;
            if (op == OP_LOAD) begin
                sec_part = secs % 60;
                // Minutes wrap at 8 bits; hundreds that find no position drop.
                min_part = (secs / 60) & 8'hFF;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (i < SEC_DIGITS) begin
                        shown[i] = t_digit'(sec_part % 10);
                        sec_part = sec_part / 10;
                    end else begin
                        shown[i] = t_digit'(min_part % 10);
                        min_part = min_part / 10;
                    end
                end
                return;
            end
            for (int i = 0; i < NUM_DIGITS; i++) begin
                pos   = (start_offset + i) % NUM_DIGITS;
                digit = shown[pos];
                f.segments = SEG_FONT[(digit < 10) ? digit : 0];
                if (pos == 1) f.segments[7] = 1'b0;
                f.select = 8'(1 << (pos & 7));
                f.last   = (i == NUM_DIGITS - 1);
                frames_due.push_back(f);
            end
            // Period zero counts as 256; a count left above a smaller new
            // period folds back through the modulo.
            refresh_cnt = (refresh_cnt + 1) % ((period == 0) ? 256 : period);
            if (refresh_cnt == 0) begin
                start_offset = step_down ? ((start_offset - 1) & 8'hFF)
                                         : ((start_offset + 1) & 8'hFF);
                if (start_offset == 1 || start_offset == NUM_DIGITS - 2)
                    step_down = !step_down;
            end
        endfunction

        // Compare one accepted frame with the oldest one owed.
        function void check_frame(input logic [7:0] seg, input logic [7:0] sel,
                                  input logic last_flag);
            t_frame want;
            if (frames_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: frame seg=%h sel=%h last=%b with none owed",
                             $realtime, seg, sel, last_flag);
                return;
            end
            want = frames_due.pop_front();
            if (want.segments !== seg || want.select !== sel || want.last !== last_flag) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: frame mismatch seg %h/%h sel %h/%h last %b/%b (exp/act)",
                             $realtime, want.segments, seg, want.select, sel,
                             want.last, last_flag);
            end
        endfunction
    endclass

    // Every block input starts at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        i_opcode      = OP_LOAD;
    logic [15:0] i_seconds     = '0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_segment_pattern;
    logic [7:0]  o_digit_select;
    logic        o_last_frame;

    frame_predictor display_model;
    int unsigned    burst_left = 0;
    bit             hold_req   = 1'b0;

    seven_segment_scan_driver_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_seconds         (i_seconds),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_segment_pattern (o_segment_pattern),
        .o_digit_select    (o_digit_select),
        .o_last_frame      (o_last_frame)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // Offer one item from a falling edge and hold it until the block takes it.
    // Between bursts drop valid and wait out a random gap before raising it
    // again, so valid is never lowered and raised in the same step.
    task automatic send_item(input logic op, input logic [15:0] secs);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_opcode   <= op;
        i_seconds  <= secs;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        burst_left--;
        display_model.note_item(op, secs);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every owed frame, then let a trailing load or
    // remainder pass run out.
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (display_model.frames_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write the rotate period only while the block sits idle.
    task automatic change_period(input logic [7:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        display_model.period = value;
    endtask

    // Bias times toward the carries: minute edges, the 255/256 minute wrap
    // and the top of the range.
    function automatic logic [15:0] pick_seconds();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 119));
            1:       return 16'($urandom_range(0, 3599));
            2:       return 16'($urandom_range(15300, 15420));
            3:       return 16'($urandom_range(65400, 65535));
            4:       return 16'($urandom_range(0, 1091) * 60 + ($urandom_range(0, 1) ? 59 : 0));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(input int unsigned count);
        logic        op;
        logic [15:0] secs;
        repeat (count) begin
            op   = ($urandom_range(0, 99) < 65) ? OP_REFRESH : OP_LOAD;
            secs = pick_seconds();
            send_item(op, secs);
        end
    endtask

    // Receiver: switch between stall patterns every so often, and honor a
    // long hold-off when asked, so the queue fills and input backs up.
    initial begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = $urandom_range(150, 250);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= (tick % 4 != 0);
                    default: i_out_ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Check every frame the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            display_model.check_frame(o_segment_pattern, o_digit_select, o_last_frame);
    end

    // Watchdog: end the run when neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main_seq
        display_model = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Blank store after reset; the seconds field is ignored on refresh.
        send_item(OP_REFRESH, 16'hFFFF);
        send_item(OP_LOAD, 16'd0);
        send_item(OP_REFRESH, 16'd0);
        // Top of the range: minutes wrap to 68.
        send_item(OP_LOAD, 16'hFFFF);
        send_item(OP_REFRESH, 16'h0000);
        send_item(OP_LOAD, 16'd59);
        send_item(OP_REFRESH, 16'd0);
        send_item(OP_LOAD, 16'd60);
        send_item(OP_REFRESH, 16'd0);
        send_item(OP_LOAD, 16'd3599);
        send_item(OP_REFRESH, 16'd0);
        // 255 minutes: the hundreds digit has no position and drops.
        send_item(OP_LOAD, 16'd15359);
        send_item(OP_REFRESH, 16'd0);
        // 256 minutes truncate to zero.
        send_item(OP_LOAD, 16'd15360);
        send_item(OP_REFRESH, 16'd0);
        // Back-to-back loads: only the second shows.
        send_item(OP_LOAD, 16'd1234);
        send_item(OP_LOAD, 16'd4321);
        send_item(OP_REFRESH, 16'd0);
        send_item(OP_REFRESH, 16'd0);

        // Period 1 below the running count: the count folds back, then the
        // offset steps every refresh, flips at 1 and wraps below 0.
        change_period(8'd1);
        send_item(OP_LOAD, 16'd12345);
        repeat (5) send_item(OP_REFRESH, 16'd0);

        hold_req = 1'b1;
        run_random(105);
        change_period(8'd255);
        hold_req = 1'b1;
        run_random(50);
        change_period(8'd0);
        run_random(50);
        change_period(8'd2);
        hold_req = 1'b1;
        run_random(40);
        change_period(8'd3);
        run_random(40);
        change_period(8'($urandom_range(1, 255)));
        run_random(45);
        drain();

        if (display_model.failures == 0 && display_model.frames_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
